/* hw/rtl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    typedef struct packed {
        logic       write_byte;  // store data byte at fill position, advance fill
        logic [7:0] byte_val;
        logic       load;        // copy chain value into working registers
        logic       round;       // run one compression round
        logic       add;         // fold working registers into chain value
        logic       absorb;      // count one full block of message bits
        logic       pad;         // apply 0x80, zeros and (if room) length
        logic       pad_len;     // zero words 0..13, length in words 14..15
        logic       init;        // restart for the next message
        logic [1:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic fill_last;   // fill is 63, next byte completes the block
        logic fill_ge56;   // no room for the length field
        logic round_done;  // round 63 in progress
    } t_sts;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [63:0] BLOCK_BITS = 64'd512;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* hw/rtl/shs_datapath.sv */
// ----------------------------------------------------------------------------
// shs_datapath
// Block buffer as a 16-word schedule window, working registers, chain value,
// fill and bit counters. One compression round per cycle.
// ----------------------------------------------------------------------------
module shs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shs_pkg::t_cmd      i_cmd,
    output shs_pkg::t_sts      o_sts,
    output logic [63:0]        o_digest_word
);

    logic [31:0] r_w     [16];
    logic [31:0] r_v     [8];
    logic [31:0] r_chain [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_round;

    logic [63:0] total_bits;
    logic [31:0] pad_w   [16];
    logic [31:0] next_w;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign total_bits = r_bits + {55'd0, r_fill, 3'd0};

    // Keep bytes below the fill, marker at the fill, zeros above.
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            for (int b = 0; b < 4; b++) begin
                if (6'(4 * j + b) < r_fill) begin
                    pad_w[j][8 * (3 - b) +: 8] = r_w[j][8 * (3 - b) +: 8];
                end else if (6'(4 * j + b) == r_fill) begin
                    pad_w[j][8 * (3 - b) +: 8] = shs_pkg::PAD_BYTE;
                end else begin
                    pad_w[j][8 * (3 - b) +: 8] = 8'd0;
                end
            end
        end
    end

    assign next_w = shs_pkg::small_sigma1(r_w[14]) + r_w[9]
                  + shs_pkg::small_sigma0(r_w[1]) + r_w[0];

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + shs_pkg::big_sigma1(r_v[4]) + ch
               + shs_pkg::round_k(r_round) + r_w[0];
    assign t2  = shs_pkg::big_sigma0(r_v[0]) + maj;

    // Schedule window / block buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte) begin
            r_w[r_fill[5:2]][8 * (3 - 32'(r_fill[1:0])) +: 8] <= i_cmd.byte_val;
        end else if (i_cmd.round) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j + 1];
            end
            r_w[15] <= next_w;
        end else if (i_cmd.pad) begin
            for (int j = 0; j < 14; j++) begin
                r_w[j] <= pad_w[j];
            end
            if (r_fill[5:3] == 3'b111) begin
                r_w[14] <= pad_w[14];
                r_w[15] <= pad_w[15];
            end else begin
                r_w[14] <= total_bits[63:32];
                r_w[15] <= total_bits[31:0];
            end
        end else if (i_cmd.pad_len) begin
            for (int j = 0; j < 14; j++) begin
                r_w[j] <= 32'd0;
            end
            r_w[14] <= total_bits[63:32];
            r_w[15] <= total_bits[31:0];
        end
    end

    // Working registers and round counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_chain[j];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= 6'd0;
            r_fill  <= 6'd0;
            r_bits  <= 64'd0;
            for (int j = 0; j < 8; j++) begin
                r_chain[j] <= shs_pkg::IV[j];
            end
        end else begin
            if (i_cmd.load) begin
                r_round <= 6'd0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.add) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= r_chain[j] + r_v[j];
                end
            end else if (i_cmd.init) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= shs_pkg::IV[j];
                end
            end
            // Fill wraps to zero on the 64th byte.
            if (i_cmd.write_byte) begin
                r_fill <= r_fill + 6'd1;
            end else if (i_cmd.init) begin
                r_fill <= 6'd0;
            end
            if (i_cmd.absorb) begin
                r_bits <= r_bits + shs_pkg::BLOCK_BITS;
            end else if (i_cmd.init) begin
                r_bits <= 64'd0;
            end
        end
    end

    assign o_sts.fill_last  = (r_fill == 6'd63);
    assign o_sts.fill_ge56  = (r_fill[5:3] == 3'b111);
    assign o_sts.round_done = (r_round == 6'd63);

    assign o_digest_word = {r_chain[{i_cmd.out_idx, 1'b0}], r_chain[{i_cmd.out_idx, 1'b1}]};

endmodule

/* hw/rtl/shs_ctrl.sv */
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: byte intake, compression passes, padding and digest output.
// ----------------------------------------------------------------------------
module shs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_has_byte,
    input  logic           i_is_last,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_word_index,
    output logic           o_last_word,
    output shs_pkg::t_cmd  o_cmd,
    input  shs_pkg::t_sts  i_sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RUN, S_ADD, S_PAD, S_PADLEN, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_ABSORB, K_EXTRA, K_FINAL
    } t_kind;

    t_state     r_state, n_state;
    t_kind      r_kind, n_kind;
    logic       r_pend_last, n_pend_last;
    logic [1:0] r_oidx, n_oidx;
    logic       in_acc;
    logic       out_acc;

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == 2'd3);
    assign in_acc       = i_valid && (r_state == S_IDLE);
    assign out_acc      = o_valid && !i_stall;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_pend_last = r_pend_last;
        n_oidx      = r_oidx;
        o_cmd            = '0;
        o_cmd.byte_val   = i_data_byte;
        o_cmd.out_idx    = r_oidx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.write_byte = i_has_byte;
                    if (i_has_byte && i_sts.fill_last) begin
                        n_kind      = K_ABSORB;
                        n_pend_last = i_is_last;
                        n_state     = S_LOAD;
                    end else if (i_is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                n_kind    = i_sts.fill_ge56 ? K_EXTRA : K_FINAL;
                n_state   = S_LOAD;
            end
            S_PADLEN: begin
                o_cmd.pad_len = 1'b1;
                n_kind        = K_FINAL;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                unique case (r_kind)
                    K_ABSORB: begin
                        o_cmd.absorb = 1'b1;
                        n_pend_last  = 1'b0;
                        n_state      = r_pend_last ? S_PAD : S_IDLE;
                    end
                    K_EXTRA: n_state = S_PADLEN;
                    K_FINAL: begin
                        n_oidx  = 2'd0;
                        n_state = S_OUT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_oidx == 2'd3) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_ABSORB;
            r_pend_last <= 1'b0;
            r_oidx      <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_pend_last <= n_pend_last;
            r_oidx      <= n_oidx;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_intake_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while digest is being emitted");

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_is_last |=> o_stall)
        else $error("last transaction did not start finishing");

    a_done_after_word3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_last_word |=> !o_valid && !o_stall)
        else $error("block not idle after final digest word");

    a_rounds_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && i_sts.round_done |=> (r_state == S_ADD))
        else $error("compression did not end after round 63");
`endif

endmodule

/* hw/rtl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; digest out as four 64-bit big-endian words.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle while it only buffers bytes. The byte
// that completes a 64-byte block starts a pass, with input stalled: load
// the working registers, run 64 rounds at one round per cycle, fold the
// result into the chain value. A last transaction adds a padding step and
// a pass (two, with a length-only step between, when 56 or more bytes are
// pending), then four output transactions, after which the hasher restarts.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    shs_pkg::t_cmd cmd;
    shs_pkg::t_sts sts;

    shs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_has_byte   (i_has_byte),
        .i_is_last    (i_is_last),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    shs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_digest_word (o_digest_word)
    );

endmodule

/* dv/sha256_stream_hasher_test.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test
// Drives byte-stream messages into the hasher and checks each digest word
// against a SHA-256 predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
class digest_scoreboard;
    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_out;

    logic [31:0] chain[8];
    logic [7:0]  buffer[64];
    int          fill;
    logic [63:0] bits_done;
    t_digest_out pending_words[$];
    int          errors;

    function new();
        errors = 0;
        restart();
        foreach (buffer[i]) buffer[i] = 8'h00;
    endfunction

    function void restart();
        foreach (chain[i]) chain[i] = shs_pkg::IV[i];
        fill = 0;
        bits_done = 64'd0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1, t2, s0, s1, ch, mj;
        for (int i = 0; i < 16; i++)
            w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = chain;
        for (int i = 0; i < 64; i++) begin
            s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + shs_pkg::round_k(i[5:0]) + w[i];
            s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // Absorb one accepted input transaction; queue four words on a last one.
    function void note_input(logic [7:0] data, logic has_byte, logic is_last);
        logic [63:0] total;
        t_digest_out d;
        if (has_byte) begin
            buffer[fill] = data;
            fill++;
            if (fill == 64) begin
                compress();
                bits_done += 64'd512;
                fill = 0;
            end
        end
        if (!is_last) return;
        total = bits_done + 64'(fill) * 64'd8;
        buffer[fill] = 8'h80;
        for (int i = fill + 1; i < 64; i++) buffer[i] = 8'h00;
        if (fill >= 56) begin
            compress();
            for (int i = 0; i < 56; i++) buffer[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) buffer[56+i] = total[63-8*i -: 8];
        compress();
        for (int k = 0; k < 4; k++) begin
            d.word  = {chain[2*k], chain[2*k+1]};
            d.index = k[1:0];
            d.last  = (k == 3);
            pending_words.push_back(d);
        end
        restart();
    endfunction

    function void check_word(logic [63:0] word, logic [1:0] index, logic last);
        t_digest_out e;
        if (pending_words.size() == 0) begin
            $display("%0t: unexpected digest word %h", $time, word);
            errors++;
            return;
        end
        e = pending_words.pop_front();
        if (word !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
            errors++;
        end
        if (index !== e.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.index, index);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: last_word expected %0d actual %0d", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module sha256_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_BYTES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_is_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard sb = new();
    int send_idle_pct = 22;
    int recv_idle_pct = 58;
    int quiet_cycles = 0;

    sha256_stream_hasher dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_data_byte, i_has_byte, i_is_last);
            if (o_valid && !i_stall) sb.check_word(o_digest_word, o_word_index, o_last_word);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one transaction, with a random gap before it; hold until accepted.
    // Valid stays high after acceptance until the next call idles or reloads it.
    task automatic send_item(logic [7:0] data, logic has_byte, logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_has_byte  <= has_byte;
        i_is_last   <= is_last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && $urandom_range(1));
        end
        // close with an empty last item unless the byte above already did
        if (len == 0 || !i_is_last) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then "abc"
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // single extreme bytes
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        // fill 56 forces the extra padding block
        for (int i = 0; i < 56; i++) send_item(8'(i), 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // exactly one block, last on the completing byte
        for (int i = 0; i < 64; i++) send_item(8'(255 - i), 1'b1, i == 63);

        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 58 : 0;
            recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 22 : 0;
            for (int n = 0; n < 36; n++) begin
                int len;
                case ($urandom_range(5))
                    0: len = $urandom_range(54, 66);
                    1: len = $urandom_range(118, 130);
                    default: len = $urandom_range(0, 12);
                endcase
                // clip to the byte budget of this phase
                if (len > PHASE_BYTES * (ph + 1) - sent) len = PHASE_BYTES * (ph + 1) - sent;
                send_message(len);
                sent += len;
                if (sent >= PHASE_BYTES * (ph + 1)) break;
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
